// File: design/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants for the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 20;
	localparam int OUT_W     = 32;
	localparam int PROD_W    = 2 * IN_W;
	localparam int COF_W     = PROD_W + 1;
	localparam int DET_W     = IN_W + COF_W;
	localparam int MAG_W     = DET_W - 1;
	localparam int THR_W     = 49;
	localparam int N_ENT     = 9;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(28147498);

	// quotient bits: integer part below 2^(2F) plus one rounding bit
	localparam int QBITS   = 2 * FRAC_BITS + 1;
	localparam int STEPS   = 3;
	localparam int DIV_CYC = (QBITS + STEPS - 1) / STEPS;
	localparam int CNT_W   = $clog2(DIV_CYC + 1);

	typedef logic signed [IN_W-1:0]  ent_t;
	typedef ent_t                    mat_t [N_ENT];
	typedef logic signed [COF_W-1:0] cof_t;
	typedef cof_t                    cof_arr_t [N_ENT];
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [THR_W-1:0]        thr_t;
	typedef logic signed [OUT_W-1:0] out_t;

	// per-cycle control from the sequencer to the divider lanes
	typedef struct packed {
		logic             load;
		logic             step;
		logic [STEPS-1:0] act;
	} div_ctl_t;

endpackage

// File: design/m3i_if.sv
// ----------------------------------------------------------------------------
// m3i_in_if / m3i_out_if
// Valid/ready channels carrying one matrix and one inverse result.
// ----------------------------------------------------------------------------
interface m3i_in_if;
	import m3i_pkg::*;
	logic valid;
	logic ready;
	ent_t in_r1c1, in_r1c2, in_r1c3;
	ent_t in_r2c1, in_r2c2, in_r2c3;
	ent_t in_r3c1, in_r3c2, in_r3c3;
	modport source (output valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2,
		in_r2c3, in_r3c1, in_r3c2, in_r3c3, input ready);
	modport sink (input valid, in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2,
		in_r2c3, in_r3c1, in_r3c2, in_r3c3, output ready);
endinterface

interface m3i_out_if;
	import m3i_pkg::*;
	logic valid;
	logic ready;
	out_t out_r1c1, out_r1c2, out_r1c3;
	out_t out_r2c1, out_r2c2, out_r2c3;
	out_t out_r3c1, out_r3c2, out_r3c3;
	logic singular;
	modport source (output valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2,
		out_r2c3, out_r3c1, out_r3c2, out_r3c3, singular, input ready);
	modport sink (input valid, out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2,
		out_r2c3, out_r3c1, out_r3c2, out_r3c3, singular, output ready);
endinterface

// File: design/m3i_cofactor.sv
// ----------------------------------------------------------------------------
// m3i_cofactor
// Five-stage pipeline: cofactors, determinant, magnitude and singular test.
// ----------------------------------------------------------------------------
module m3i_cofactor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  m3i_pkg::mat_t     mat,
	input  m3i_pkg::thr_t     thr,
	output logic              out_vld,
	output m3i_pkg::cof_arr_t cof,
	output m3i_pkg::mag_t     det_mag,
	output logic              det_neg,
	output logic              sing
);
	import m3i_pkg::*;

	localparam int LO_W = 21;
	localparam int HI_W = COF_W - LO_W;
	localparam int PL_W = IN_W + LO_W + 1;

	// cofactor j = m[PX]*m[PY] - m[QX]*m[QY], entries in row-major order
	localparam int PX [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PY [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int QX [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	localparam int QY [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};

	logic signed [PROD_W-1:0] p_s1 [N_ENT];
	logic signed [PROD_W-1:0] q_s1 [N_ENT];
	ent_t                     c_s1 [3];
	cof_t                     cof_s2 [N_ENT];
	ent_t                     c_s2 [3];
	cof_t                     cof_s3 [N_ENT];
	logic signed [PROD_W-1:0] ph_s3 [3];
	logic signed [PL_W-1:0]   pl_s3 [3];
	cof_t                     cof_s4 [N_ENT];
	logic signed [DET_W-1:0]  det_s4;
	cof_t                     cof_s5 [N_ENT];
	mag_t                     mag_s5;
	logic                     neg_s5;
	logic [4:0]               vld_q;
	logic signed [DET_W-1:0]  hsum, lsum;
	logic [DET_W-1:0]         dabs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_vld};
		end
	end

	always_comb begin
		hsum = DET_W'(ph_s3[0]) + DET_W'(ph_s3[1]) + DET_W'(ph_s3[2]);
		lsum = DET_W'(pl_s3[0]) + DET_W'(pl_s3[1]) + DET_W'(pl_s3[2]);
		dabs = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < N_ENT; j++) begin
				p_s1[j]   <= mat[PX[j]] * mat[PY[j]];
				q_s1[j]   <= mat[QX[j]] * mat[QY[j]];
				cof_s2[j] <= COF_W'(p_s1[j]) - COF_W'(q_s1[j]);
				cof_s3[j] <= cof_s2[j];
				cof_s4[j] <= cof_s3[j];
				cof_s5[j] <= cof_s4[j];
			end
			c_s1[0] <= mat[0];
			c_s1[1] <= mat[3];
			c_s1[2] <= mat[6];
			c_s2    <= c_s1;
			// column-1 expansion, cofactor split into high and low parts
			for (int i = 0; i < 3; i++) begin
				ph_s3[i] <= c_s2[i] * $signed(cof_s2[i][COF_W-1 -: HI_W]);
				pl_s3[i] <= c_s2[i] * $signed({1'b0, cof_s2[i][LO_W-1:0]});
			end
			det_s4 <= (hsum <<< LO_W) + lsum;
			mag_s5 <= dabs[MAG_W-1:0];
			neg_s5 <= det_s4[DET_W-1];
		end
	end

	assign out_vld = vld_q[4];
	assign cof     = cof_s5;
	assign det_mag = mag_s5;
	assign det_neg = neg_s5;
	assign sing    = (mag_s5 == '0) || (mag_s5 < MAG_W'(thr));

endmodule

// File: design/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// One divider lane: rounded, saturated cofactor / determinant, radix-2 steps.
// ----------------------------------------------------------------------------
module m3i_div_lane (
	input  logic                clk,
	input  m3i_pkg::div_ctl_t   ctl,
	input  m3i_pkg::cof_t       cof,
	input  logic                det_neg,
	input  m3i_pkg::mag_t       dload,
	input  m3i_pkg::mag_t       d,
	output m3i_pkg::out_t       res
);
	import m3i_pkg::*;

	localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF;
	localparam logic [63:0] NEG_LIM = 64'h8000_0000;

	mag_t             rem_q;
	logic [QBITS-1:0] quo_q;
	logic             neg_q;
	logic             big_q;

	logic [COF_W-1:0] cabs;
	mag_t             cmag;
	mag_t             rem_n;
	logic [QBITS-1:0] quo_n;
	logic [MAG_W:0]   r2;
	logic [QBITS-1:0] qr;
	logic [63:0]      wide;

	always_comb begin
		cabs  = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
		cmag  = MAG_W'(cabs);
		rem_n = rem_q;
		quo_n = quo_q;
		r2    = '0;
		for (int k = 0; k < STEPS; k++) begin
			if (ctl.act[k]) begin
				r2 = {rem_n, 1'b0};
				if (r2 >= {1'b0, d}) begin
					r2    = r2 - {1'b0, d};
					quo_n = {quo_n[QBITS-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[QBITS-2:0], 1'b0};
				end
				rem_n = r2[MAG_W-1:0];
			end
		end
		// last quotient bit is the half bit: ties round away from zero
		qr   = (quo_q >> 1) + QBITS'(quo_q[0]);
		wide = 64'(qr);
		if (!neg_q) begin
			res = (big_q || wide > POS_LIM) ? OUT_W'(POS_LIM) : OUT_W'(wide);
		end else begin
			res = (big_q || wide > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(-wide);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= cmag;
			quo_q <= '0;
			neg_q <= cof[COF_W-1] ^ det_neg;
			big_q <= cmag >= dload;
		end else if (ctl.step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

endmodule

// File: design/matrix3x3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// 3x3 fixed-point matrix inverse by adjugate with nine parallel divider lanes.
// ----------------------------------------------------------------------------
// Path: cofactor/determinant pipeline, load into the lanes, divide steps
//   (33 quotient bits, 3 per cycle in each lane), then 1 output register.
// The shared divider lanes set the pace and take no new matrix until the last
//   result moves out; the front pipeline takes the next one during a division.
// Reset: arst_n clears valid and sequencer state; threshold returns to 1e-7.
module matrix3x3_inverse_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [m3i_pkg::THR_W-1:0] cfg_wdata,
	m3i_in_if.sink                    in_ch,
	m3i_out_if.source                 out_ch
);
	import m3i_pkg::*;

	thr_t             thr_q;
	mat_t             mat;
	logic             fe_en;
	logic             fe_vld;
	cof_arr_t         fe_cof;
	mag_t             fe_mag;
	logic             fe_neg;
	logic             fe_sing;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	mag_t             dmag_q;
	logic             sing_q;
	logic             done;
	logic             xfer;
	div_ctl_t         ctl;
	out_t             lane_res [N_ENT];
	out_t             res_q [N_ENT];
	logic             osing_q;
	logic             ovld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign mat = '{in_ch.in_r1c1, in_ch.in_r1c2, in_ch.in_r1c3,
	               in_ch.in_r2c1, in_ch.in_r2c2, in_ch.in_r2c3,
	               in_ch.in_r3c1, in_ch.in_r3c2, in_ch.in_r3c3};

	always_comb begin
		done     = busy_q && (cnt_q == CNT_W'(DIV_CYC));
		xfer     = done && (!ovld_q || out_ch.ready);
		ctl.load = fe_vld && (!busy_q || xfer);
		ctl.step = busy_q && !done;
		for (int k = 0; k < STEPS; k++) begin
			ctl.act[k] = (int'(cnt_q) * STEPS + k) < QBITS;
		end
		fe_en       = !fe_vld || ctl.load;
		in_ch.ready = fe_en;
	end

	m3i_cofactor u_cof (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (fe_en),
		.in_vld  (in_ch.valid),
		.mat     (mat),
		.thr     (thr_q),
		.out_vld (fe_vld),
		.cof     (fe_cof),
		.det_mag (fe_mag),
		.det_neg (fe_neg),
		.sing    (fe_sing)
	);

	for (genvar j = 0; j < N_ENT; j++) begin : g_lane
		m3i_div_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.cof     (fe_cof[j]),
			.det_neg (fe_neg),
			.dload   (fe_mag),
			.d       (dmag_q),
			.res     (lane_res[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (xfer) begin
				busy_q <= 1'b0;
			end else if (ctl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (xfer) begin
				ovld_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// merge: latch divisor and singular flag on load, gather lanes, zero all entries on a singular matrix
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dmag_q <= fe_mag;
			sing_q <= fe_sing;
		end
		if (xfer) begin
			for (int j = 0; j < N_ENT; j++) begin
				res_q[j] <= sing_q ? '0 : lane_res[j];
			end
			osing_q <= sing_q;
		end
	end

	assign out_ch.valid    = ovld_q;
	assign out_ch.out_r1c1 = res_q[0];
	assign out_ch.out_r1c2 = res_q[1];
	assign out_ch.out_r1c3 = res_q[2];
	assign out_ch.out_r2c1 = res_q[3];
	assign out_ch.out_r2c2 = res_q[4];
	assign out_ch.out_r2c3 = res_q[5];
	assign out_ch.out_r3c1 = res_q[6];
	assign out_ch.out_r3c2 = res_q[7];
	assign out_ch.out_r3c3 = res_q[8];
	assign out_ch.singular = osing_q;

endmodule
